@@ sv/bookmark_ring_floor_lookup_core_defines.svh @@
// assertion macros shared by the bookmark ring checker
`ifndef BOOKMARK_RING_FLOOR_LOOKUP_CORE_DEFINES_SVH
`define BOOKMARK_RING_FLOOR_LOOKUP_CORE_DEFINES_SVH

// plain property, checked on every rising edge outside reset
`define BRFL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the following edge
`define BRFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/brfl_pkg.sv @@
// types and constants of the bookmark ring floor lookup
package brfl_pkg;

  localparam int unsigned IDX_W = 32;
  localparam int unsigned PAY_W = 64;
  localparam int unsigned CAP_W = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;
  localparam logic [IDX_W-1:0] DIFF_INIT = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_e;

  typedef struct packed {
    action_e           action;
    logic [IDX_W-1:0]  log_index;
    logic [PAY_W-1:0]  entry_payload;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  found_index;
    logic [PAY_W-1:0]  found_payload;
  } rsp_t;

  // search token moving along the cell row
  typedef struct packed {
    logic              vld;
    logic              found;
    logic [IDX_W-1:0]  query;
    logic [IDX_W-1:0]  best;
    logic [IDX_W-1:0]  hit_index;
  } tok_t;

endpackage

@@ sv/brfl_cell.sv @@
// one ring slot holding a bookmark and one stage of the search token
module brfl_cell #(
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [brfl_pkg::IDX_W-1:0]    wr_index_i,
  input  logic [PAYLOAD_WIDTH-1:0]      wr_payload_i,
  input  logic                          live_i,
  input  brfl_pkg::tok_t                tok_i,
  input  logic [PAYLOAD_WIDTH-1:0]      pay_i,
  output brfl_pkg::tok_t                tok_o,
  output logic [PAYLOAD_WIDTH-1:0]      pay_o
);

  logic [brfl_pkg::IDX_W-1:0] idx_q;
  logic [PAYLOAD_WIDTH-1:0]   mark_pay_q;
  brfl_pkg::tok_t             tok_q, tok_d;
  logic [PAYLOAD_WIDTH-1:0]   pay_q, pay_d;
  logic [brfl_pkg::IDX_W-1:0] diff;
  logic                       take;

  // slot storage, undefined until written
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      idx_q      <= wr_index_i;
      mark_pay_q <= wr_payload_i;
    end
  end

  // strict less keeps the lower slot on ties
  always_comb begin
    diff  = tok_i.query - idx_q;
    take  = live_i && (idx_q <= tok_i.query) && (diff < tok_i.best);
    tok_d = tok_i;
    pay_d = pay_i;
    if (take) begin
      tok_d.found     = 1'b1;
      tok_d.best      = diff;
      tok_d.hit_index = idx_q;
      pay_d           = mark_pay_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      pay_q <= '0;
    end else begin
      tok_q <= tok_d;
      pay_q <= pay_d;
    end
  end

  assign tok_o = tok_q;
  assign pay_o = pay_q;

endmodule

@@ sv/bookmark_ring_floor_lookup_core.sv @@
// top level of the bookmark ring with floor lookup
// lookup: the result strobes on done_o once the token leaves the last cell; busy stays high
//   until the strobe cycle ends, so a new lookup is taken only after the last one's result
// the wait is set by the search token walking the row of DEPTH slot cells, one cell a cycle
// clear and add never raise busy and can follow each other every cycle while busy is low
// the receiver cannot stall; results are shown for one cycle only
// reset (rst_ni low, asynchronous) empties the ring, sets capacity to 32, drops any token
module bookmark_ring_floor_lookup_core #(
  parameter int unsigned DEPTH         = 32,
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  brfl_pkg::req_t                req_i,
  // result channel
  output logic                          done_o,
  output brfl_pkg::rsp_t                rsp_o,
  // capacity register
  input  logic                          cfg_we_i,
  input  logic [brfl_pkg::CAP_W-1:0]    cfg_wdata_i
);

  // count width holds DEPTH itself, slot width indexes DEPTH cells
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // compare width for counts against the 6-bit capacity
  localparam int unsigned CMP_W  = (CNT_W > brfl_pkg::CAP_W) ? CNT_W : brfl_pkg::CAP_W;

  logic [brfl_pkg::CAP_W-1:0] capacity_q;
  logic [CNT_W-1:0]           valid_count_q, valid_count_d;
  logic [SLOT_W-1:0]          next_slot_q, next_slot_d;
  logic                       busy_q, busy_d;

  logic [CMP_W-1:0]  eff_cap;
  logic [CMP_W-1:0]  slot_inc;
  logic [SLOT_W-1:0] wr_slot;
  logic              accept;
  logic              add_go;
  logic              lookup_go;

  brfl_pkg::tok_t             tok_chain [DEPTH+1];
  logic [PAYLOAD_WIDTH-1:0]   pay_chain [DEPTH+1];
  logic [DEPTH-1:0]           wr_en;
  logic [DEPTH-1:0]           live;

  assign accept = start && !busy_q;

  // capacity above DEPTH saturates at DEPTH
  always_comb begin
    if (CMP_W'(capacity_q) > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = CMP_W'(capacity_q);
    end
  end

  // a write pointer left past a lowered capacity restarts at slot 0
  always_comb begin
    if (CMP_W'(next_slot_q) < eff_cap) begin
      wr_slot = next_slot_q;
    end else begin
      wr_slot = '0;
    end
    slot_inc = CMP_W'(wr_slot) + CMP_W'(1);
  end

  // request decode; the unused action code is dropped
  always_comb begin
    add_go    = 1'b0;
    lookup_go = 1'b0;
    if (accept) begin
      unique case (req_i.action)
        brfl_pkg::ACT_CLEAR:  add_go    = 1'b0;
        brfl_pkg::ACT_ADD:    add_go    = (eff_cap != '0);
        brfl_pkg::ACT_LOOKUP: lookup_go = 1'b1;
        default:              lookup_go = 1'b0;
      endcase
    end
  end

  // ring bookkeeping next state
  always_comb begin
    valid_count_d = valid_count_q;
    next_slot_d   = next_slot_q;
    if (accept && (req_i.action == brfl_pkg::ACT_CLEAR)) begin
      valid_count_d = '0;
      next_slot_d   = '0;
    end else if (add_go) begin
      if (CMP_W'(valid_count_q) < eff_cap) begin
        valid_count_d = valid_count_q + CNT_W'(1);
      end
      if (slot_inc >= eff_cap) begin
        next_slot_d = '0;
      end else begin
        next_slot_d = SLOT_W'(slot_inc);
      end
    end
  end

  // busy covers a lookup from acceptance through its strobe cycle
  always_comb begin
    busy_d = busy_q;
    if (lookup_go) begin
      busy_d = 1'b1;
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q    <= brfl_pkg::CAP_RESET;
      valid_count_q <= '0;
      next_slot_q   <= '0;
      busy_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      valid_count_q <= valid_count_d;
      next_slot_q   <= next_slot_d;
      busy_q        <= busy_d;
    end
  end

  // token injected into the head cell on a lookup
  always_comb begin
    tok_chain[0].vld       = lookup_go;
    tok_chain[0].found     = 1'b0;
    tok_chain[0].query     = req_i.log_index;
    tok_chain[0].best      = brfl_pkg::DIFF_INIT;
    tok_chain[0].hit_index = '0;
    pay_chain[0]           = '0;
  end

  // row of slot cells; cell i holds ring slot i
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    // a cell takes part only below the fill count
    assign live[gi]  = (CNT_W'(gi) < valid_count_q);
    assign wr_en[gi] = add_go && (wr_slot == SLOT_W'(gi));

    brfl_cell #(
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .wr_en_i      (wr_en[gi]),
      .wr_index_i   (req_i.log_index),
      .wr_payload_i (req_i.entry_payload[PAYLOAD_WIDTH-1:0]),
      .live_i       (live[gi]),
      .tok_i        (tok_chain[gi]),
      .pay_i        (pay_chain[gi]),
      .tok_o        (tok_chain[gi+1]),
      .pay_o        (pay_chain[gi+1])
    );
  end

  // tail of the row drives the result; a miss carries zeros from the head
  assign busy                = busy_q;
  assign done_o              = tok_chain[DEPTH].vld;
  assign rsp_o.found         = tok_chain[DEPTH].found;
  assign rsp_o.found_index   = tok_chain[DEPTH].hit_index;
  assign rsp_o.found_payload = brfl_pkg::PAY_W'(pay_chain[DEPTH]);

endmodule

@@ sv/brfl_checker.sv @@
// port-level checker for the bookmark ring, bound to the top level
`include "bookmark_ring_floor_lookup_core_defines.svh"

module brfl_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  brfl_pkg::req_t              req_i,
  input  logic                        done_o,
  input  brfl_pkg::rsp_t              rsp_o
);

  // a result only appears while a lookup is in flight
`BRFL_ASSERT(a_done_in_busy, clk_i, rst_ni, !done_o || busy, "result strobe outside a lookup")

  // a miss reports zero index and zero payload
`BRFL_ASSERT(a_miss_zero, clk_i, rst_ni, !(done_o && !rsp_o.found) || ((rsp_o.found_index == '0) && (rsp_o.found_payload == '0)), "miss with nonzero fields")

  // the block frees itself right after the result
`BRFL_ASSERT_NEXT(a_free_after, clk_i, rst_ni, done_o, !busy && !done_o, "busy held after result")

  // an accepted lookup holds the block
`BRFL_ASSERT_NEXT(a_lookup_busy, clk_i, rst_ni, start && !busy && (req_i.action == brfl_pkg::ACT_LOOKUP), busy, "lookup did not raise busy")

  // clear, add and the unused action code never hold the block
`BRFL_ASSERT_NEXT(a_write_free, clk_i, rst_ni, start && !busy && (req_i.action != brfl_pkg::ACT_LOOKUP), !busy, "clear or add raised busy")

endmodule

bind bookmark_ring_floor_lookup_core brfl_checker u_brfl_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
